// ----- hdl/rtwde_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtwde_pkg - shared types and helpers of the tag write downlink encoder
// Payload structs, command and phase codes, register map and segment
// length selection used by the front, back and top level.
// ----------------------------------------------------------------------------
package rtwde_pkg;

   localparam int TICK_W       = 10;
   localparam int FRAME_W      = 70;   // opcode, password, lock, data, address
   localparam int BIT_CNT_W    = 7;
   localparam int CSR_INDEX_W  = 3;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [BIT_CNT_W-1:0] FRAME_BITS_PW   = 7'd70;
   localparam logic [BIT_CNT_W-1:0] FRAME_BITS_NOPW = 7'd38;
   localparam logic [BIT_CNT_W-1:0] RESET_BITS      = 7'd2;
   localparam logic [TICK_W-1:0]    TAIL_ON_TICKS   = 10'd200;
   localparam logic [TICK_W-1:0]    TAIL_GAP_TICKS  = 10'd27;

   // register map
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_ON      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_ON       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_GAP      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_GAP    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHARGE_WAIT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROGRAM_WAIT = 3'd5;

   // command codes on the request word
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_TAIL  = 2'd2;
   localparam logic [1:0] CMD_OFF   = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic        page_sel;
      logic [2:0]  block_addr;
      logic        lock_flag;
      logic [31:0] block_word;
      logic        use_password;
      logic [31:0] password_word;
   } req_type;

   typedef struct packed {
      logic field_on;
      logic busy_res;
      logic done_res;
      logic rejected;
   } rsp_type;

   typedef struct packed {
      logic [TICK_W-1:0] zero_on_ticks;
      logic [TICK_W-1:0] one_on_ticks;
      logic [TICK_W-1:0] bit_gap_ticks;
      logic [TICK_W-1:0] start_gap_ticks;
      logic [TICK_W-1:0] charge_wait_ticks;
      logic [TICK_W-1:0] program_wait_ticks;
   } cfg_type;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_TAIL  = 2'd2,
      KIND_OFF   = 2'd3
   } kind_type;

   // classified word as it sits in the queue; frame is left-justified
   typedef struct packed {
      kind_type             kind;
      logic                 use_pw;
      logic [FRAME_W-1:0]   frame;
   } q_item_type;

   typedef enum logic [11:0] {
      PH_IDLE   = 12'b0000_0000_0001,
      PH_CHARGE = 12'b0000_0000_0010,
      PH_SGAP   = 12'b0000_0000_0100,
      PH_BON    = 12'b0000_0000_1000,
      PH_BGAP   = 12'b0000_0001_0000,
      PH_PROG   = 12'b0000_0010_0000,
      PH_WAIT2  = 12'b0000_0100_0000,
      PH_RGAP   = 12'b0000_1000_0000,
      PH_RON    = 12'b0001_0000_0000,
      PH_RBGAP  = 12'b0010_0000_0000,
      PH_TON    = 12'b0100_0000_0000,
      PH_TGAP   = 12'b1000_0000_0000
   } phase_type;

   // tick count of a segment; zero counts as one tick
   function automatic logic [TICK_W-1:0] seg_len(phase_type ph, logic one_bit, cfg_type cfg);
      logic [TICK_W-1:0] n;
      unique case (ph) inside
         PH_CHARGE, PH_WAIT2: n = cfg.charge_wait_ticks;
         PH_SGAP, PH_RGAP:    n = cfg.start_gap_ticks;
         PH_BON, PH_RON:      n = one_bit ? cfg.one_on_ticks : cfg.zero_on_ticks;
         PH_BGAP, PH_RBGAP:   n = cfg.bit_gap_ticks;
         PH_PROG:             n = cfg.program_wait_ticks;
         PH_TON:              n = TAIL_ON_TICKS;
         PH_TGAP:             n = TAIL_GAP_TICKS;
         default:             n = TICK_W'(1);
      endcase
      return (n == '0) ? TICK_W'(1) : n;
   endfunction

   function automatic logic phase_level(phase_type ph);
      logic lvl;
      unique case (ph) inside
         PH_SGAP, PH_BGAP, PH_RGAP, PH_RBGAP, PH_TGAP: lvl = 1'b0;
         default:                                     lvl = 1'b1;
      endcase
      return lvl;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/rtwde_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtwde_front - request intake and classification
// Decodes each request word, packs the downlink frame bits and holds the
// result in a short queue for the sequencer.
// ----------------------------------------------------------------------------
module rtwde_front #(
   parameter int QUEUE_DEPTH = rtwde_pkg::QUEUE_DEPTH
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire rtwde_pkg::req_type      req_data,
   output logic                         q_valid,
   output rtwde_pkg::q_item_type        q_item,
   input  wire                          q_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   rtwde_pkg::q_item_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   rtwde_pkg::q_item_type cls_item;
   logic push;

   // classify the command and pack the frame, opcode bit first
   always_comb begin
      unique case (req_data.cmd)
         rtwde_pkg::CMD_WRITE: cls_item.kind = rtwde_pkg::KIND_WRITE;
         rtwde_pkg::CMD_TAIL:  cls_item.kind = rtwde_pkg::KIND_TAIL;
         rtwde_pkg::CMD_OFF:   cls_item.kind = rtwde_pkg::KIND_OFF;
         default:              cls_item.kind = rtwde_pkg::KIND_TICK;
      endcase
      cls_item.use_pw = req_data.use_password;
      if (req_data.use_password) begin
         cls_item.frame = {1'b1, req_data.page_sel, req_data.password_word,
                           req_data.lock_flag, req_data.block_word, req_data.block_addr};
      end else begin
         cls_item.frame = {1'b1, req_data.page_sel, req_data.lock_flag,
                           req_data.block_word, req_data.block_addr, 32'd0};
      end
   end

   assign req_stall = (count_ff == FULL_CNT);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !q_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && q_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cls_item;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/rtwde_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtwde_back - segment sequencer and response register
// Runs one field clock per queued word: applies the command, counts down
// the current segment, steps the phase and registers the response word.
// ----------------------------------------------------------------------------
module rtwde_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire rtwde_pkg::cfg_type      cfg,
   input  wire                          q_valid,
   input  wire rtwde_pkg::q_item_type   q_item,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output rtwde_pkg::rsp_type           rsp_data
);

   localparam int TW = rtwde_pkg::TICK_W;
   localparam int BW = rtwde_pkg::BIT_CNT_W;
   localparam int FW = rtwde_pkg::FRAME_W;

   logic                     carrier_ff;
   logic                     running_ff;
   rtwde_pkg::phase_type     phase_ff;
   logic [BW-1:0]            bit_cnt_ff;
   logic [TW-1:0]            tick_ff;
   logic [FW-1:0]            frame_ff;
   logic                     use_pw_ff;
   logic                     is_write_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rtwde_pkg::rsp_type       rsp_data_ff, rsp_res;

   // state after the command has been applied
   logic                     c_car, c_run, c_pw, c_wr;
   rtwde_pkg::phase_type     c_ph;
   logic [BW-1:0]            c_bc;
   logic [TW-1:0]            c_tick;
   logic [FW-1:0]            c_frame;
   logic [BW-1:0]            frame_total;

   // state after the field clock has been counted
   rtwde_pkg::rsp_type       step_rsp;
   logic                     s_car, s_run;
   rtwde_pkg::phase_type     s_ph;
   logic [BW-1:0]            s_bc;
   logic [TW-1:0]            s_tick;
   logic [FW-1:0]            s_frame;

   assign q_pop     = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      c_car   = carrier_ff;
      c_run   = running_ff;
      c_ph    = phase_ff;
      c_bc    = bit_cnt_ff;
      c_tick  = tick_ff;
      c_frame = frame_ff;
      c_pw    = use_pw_ff;
      c_wr    = is_write_ff;
      rsp_res = '0;

      unique case (q_item.kind) inside
         rtwde_pkg::KIND_OFF: begin
            c_run  = 1'b0;
            c_ph   = rtwde_pkg::PH_IDLE;
            c_tick = '0;
            c_bc   = '0;
            c_car  = 1'b0;
         end
         rtwde_pkg::KIND_WRITE, rtwde_pkg::KIND_TAIL: begin
            if (c_run) begin
               rsp_res.rejected = 1'b1;
            end else begin
               c_car = 1'b1;
               c_run = 1'b1;
               c_bc  = '0;
               if (q_item.kind == rtwde_pkg::KIND_WRITE) begin
                  c_frame = q_item.frame;
                  c_pw    = q_item.use_pw;
                  c_wr    = 1'b1;
                  c_ph    = rtwde_pkg::PH_CHARGE;
               end else begin
                  c_wr    = 1'b0;
                  c_ph    = rtwde_pkg::PH_RGAP;
               end
               c_tick = rtwde_pkg::seg_len(c_ph, 1'b0, cfg);
            end
         end
         default: ;
      endcase
   end

   assign frame_total = c_pw ? rtwde_pkg::FRAME_BITS_PW : rtwde_pkg::FRAME_BITS_NOPW;

   // count down and step to the next segment
   always_comb begin
      s_car    = c_car;
      s_run    = c_run;
      s_ph     = c_ph;
      s_bc     = c_bc;
      s_tick   = c_tick;
      s_frame  = c_frame;
      step_rsp = rsp_res;
      if (c_run) begin
         step_rsp.field_on = rtwde_pkg::phase_level(c_ph);
         step_rsp.busy_res = 1'b1;
         if (c_tick > TW'(1)) begin
            s_tick = c_tick - TW'(1);
         end else begin
            unique case (c_ph)
               rtwde_pkg::PH_CHARGE: begin
                  s_ph = rtwde_pkg::PH_SGAP;
               end
               rtwde_pkg::PH_SGAP: begin
                  s_bc = '0;
                  s_ph = rtwde_pkg::PH_BON;
               end
               rtwde_pkg::PH_BON: begin
                  s_ph = rtwde_pkg::PH_BGAP;
               end
               rtwde_pkg::PH_BGAP: begin
                  s_bc    = c_bc + BW'(1);
                  s_frame = {c_frame[FW-2:0], 1'b0};
                  if (s_bc < frame_total) begin
                     s_ph = rtwde_pkg::PH_BON;
                  end else begin
                     s_ph = rtwde_pkg::PH_PROG;
                  end
               end
               rtwde_pkg::PH_PROG: begin
                  s_ph = rtwde_pkg::PH_WAIT2;
               end
               rtwde_pkg::PH_WAIT2: begin
                  s_bc = '0;
                  s_ph = rtwde_pkg::PH_RGAP;
               end
               rtwde_pkg::PH_RGAP: begin
                  s_bc = '0;
                  s_ph = rtwde_pkg::PH_RON;
               end
               rtwde_pkg::PH_RON: begin
                  s_ph = rtwde_pkg::PH_RBGAP;
               end
               rtwde_pkg::PH_RBGAP: begin
                  s_bc = c_bc + BW'(1);
                  if (s_bc < rtwde_pkg::RESET_BITS) begin
                     s_ph = rtwde_pkg::PH_RON;
                  end else if (c_wr) begin
                     // block write ends with the carrier left on
                     s_run = 1'b0;
                     s_ph  = rtwde_pkg::PH_IDLE;
                     s_bc  = '0;
                     s_car = 1'b1;
                  end else begin
                     s_ph = rtwde_pkg::PH_TON;
                  end
               end
               rtwde_pkg::PH_TON: begin
                  s_ph = rtwde_pkg::PH_TGAP;
               end
               default: begin
                  // end of the tail: carrier off
                  s_run = 1'b0;
                  s_ph  = rtwde_pkg::PH_IDLE;
                  s_bc  = '0;
                  s_car = 1'b0;
               end
            endcase
            if (s_run) begin
               // bit value for an on-window: current frame bit, or reset pattern 1 then 0
               s_tick = rtwde_pkg::seg_len(s_ph,
                           (s_ph == rtwde_pkg::PH_RON) ? (s_bc == '0) : s_frame[FW-1], cfg);
            end else begin
               s_tick = '0;
            end
         end
         step_rsp.done_res = !s_run;
      end else begin
         step_rsp.field_on = c_car;
      end
   end

   assign rsp_valid_in = q_pop || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_ff   <= 1'b0;
         running_ff   <= 1'b0;
         phase_ff     <= rtwde_pkg::PH_IDLE;
         bit_cnt_ff   <= '0;
         tick_ff      <= '0;
         is_write_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            carrier_ff  <= s_car;
            running_ff  <= s_run;
            phase_ff    <= s_ph;
            bit_cnt_ff  <= s_bc;
            tick_ff     <= s_tick;
            is_write_ff <= c_wr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         frame_ff    <= s_frame;
         use_pw_ff   <= c_pw;
         rsp_data_ff <= step_rsp;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/rfid_tag_write_downlink_encoder_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rfid_tag_write_downlink_encoder_core - LF tag block write envelope encoder
// Turns a stream of field-clock words into the carrier on/off envelope
// that writes one 32-bit block (or sends the final reset tail) to a tag.
// ----------------------------------------------------------------------------
// Usage:
//   Send one request word per field clock on req_*: cmd 0 is a plain tick,
//   1 starts a block write (operands sampled on that word only), 2 starts
//   the final reset tail, 3 drops the carrier and aborts any sequence.
//   Every request word yields exactly one response word on rsp_*: the
//   carrier level for that clock plus busy, done and rejected flags.
//   A start word that arrives while a sequence runs is flagged rejected.
// Path: a request word is written into the queue; the back end pops it when
//   the response register is free or its word is taken, and registers the
//   response word there.
// Throughput: one word per cycle while rsp_stall is low, set by the back-end
//   sequencer; req_stall rises only when the two-entry queue is full.
// Stall: while rsp_stall holds the response word, the sequencer waits and
//   the queue fills; req_stall then holds the sender off.
// Reset: clears queue, sequencer and response register and restores the
//   timing registers to their defaults. csr_* writes take effect at once and
//   belong in idle periods.
// ----------------------------------------------------------------------------
module rfid_tag_write_downlink_encoder_core #(
   parameter int QUEUE_DEPTH = rtwde_pkg::QUEUE_DEPTH
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire rtwde_pkg::req_type                req_data,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output rtwde_pkg::rsp_type                     rsp_data,
   input  wire                                    csr_we,
   input  wire  [rtwde_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [rtwde_pkg::TICK_W-1:0]           csr_wdata
);

   rtwde_pkg::cfg_type     cfg_ff, cfg_in;
   logic                   q_valid;
   logic                   q_pop;
   rtwde_pkg::q_item_type  q_item;

   // timing register file; unknown indexes drop silently
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            rtwde_pkg::CSR_ZERO_ON:      cfg_in.zero_on_ticks      = csr_wdata;
            rtwde_pkg::CSR_ONE_ON:       cfg_in.one_on_ticks       = csr_wdata;
            rtwde_pkg::CSR_BIT_GAP:      cfg_in.bit_gap_ticks      = csr_wdata;
            rtwde_pkg::CSR_START_GAP:    cfg_in.start_gap_ticks    = csr_wdata;
            rtwde_pkg::CSR_CHARGE_WAIT:  cfg_in.charge_wait_ticks  = csr_wdata;
            rtwde_pkg::CSR_PROGRAM_WAIT: cfg_in.program_wait_ticks = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_on_ticks      <= 10'd14;
         cfg_ff.one_on_ticks       <= 10'd46;
         cfg_ff.bit_gap_ticks      <= 10'd10;
         cfg_ff.start_gap_ticks    <= 10'd30;
         cfg_ff.charge_wait_ticks  <= 10'd500;
         cfg_ff.program_wait_ticks <= 10'd700;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: classify and queue request words
   rtwde_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   // back: segment sequencer, one word per cycle while rsp_stall is low
   rtwde_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ----- hdl/rtwde_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtwde_checker - port-level checks of the downlink encoder
// Watches the request and response channels and flags flag combinations
// and reset behavior that the encoder must never show.
// ----------------------------------------------------------------------------
module rtwde_checker (
   input wire                     clock,
   input wire                     reset,
   input wire                     req_stall,
   input wire                     rsp_valid,
   input wire                     rsp_stall,
   input wire rtwde_pkg::rsp_type rsp_data
);

   // hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // a done pulse only ends a running sequence
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> rsp_data.busy_res)
      else $error("done without busy");

   // a rejected start leaves the running sequence busy on that clock
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rejected |-> rsp_data.busy_res)
      else $error("rejected without busy");

   // reset empties queue and response register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not empty after reset");

endmodule

bind rfid_tag_write_downlink_encoder_core rtwde_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
